FILE: hw/rtl/aso_pkg.sv
package aso_pkg;

   localparam int SET_CAPACITY = 32;
   localparam int DATA_W       = 32;
   localparam int MODE_W       = 2;
   localparam int IDX_W        = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CNT_W        = $clog2(SET_CAPACITY + 1);

   localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INTER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;

   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_NEXT   = 7'b0000100,
      ST_GRAB   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_DECIDE = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // pass over the outer set
   typedef enum logic [1:0] {
      PH_UNION_A = 2'd0,
      PH_UNION_B = 2'd1,
      PH_INTER   = 2'd2,
      PH_DIFF    = 2'd3
   } phase_type;

endpackage

FILE: hw/rtl/aso_if.sv
interface aso_req_if;
   logic                              valid;
   logic                              ready;
   logic                              which_set;
   logic signed [aso_pkg::DATA_W-1:0] element_value;
   logic                              last_of_b;

   modport source (output valid, which_set, element_value, last_of_b, input ready);
   modport sink   (input valid, which_set, element_value, last_of_b, output ready);
endinterface

interface aso_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [aso_pkg::DATA_W-1:0] result_value;
   logic                              result_last;
   logic                              result_empty;
   logic                              capacity_overflow;

   modport source (output valid, result_value, result_last, result_empty, capacity_overflow,
                   input ready);
   modport sink   (input valid, result_value, result_last, result_empty, capacity_overflow,
                   output ready);
endinterface

interface aso_csr_if;
   logic                              valid;
   logic                              ready;
   logic [aso_pkg::MODE_W-1:0]        operation_mode;

   modport source (output valid, operation_mode, input ready);
   modport sink   (input valid, operation_mode, output ready);
endinterface

FILE: hw/rtl/aso_set_store.sv
module aso_set_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [aso_pkg::IDX_W-1:0]  wr_addr,
   input  logic [aso_pkg::DATA_W-1:0] wr_data,
   input  logic [aso_pkg::IDX_W-1:0]  rd_addr,
   output logic [aso_pkg::DATA_W-1:0] rd_data
);

   logic [aso_pkg::DATA_W-1:0] mem [0:aso_pkg::SET_CAPACITY-1];
   logic [aso_pkg::DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/array_set_operation_engine.sv
// channel  dir  handshake          beat carries
// req_chan in   valid/ready        which_set, element_value, last_of_b
// rsp_chan out  valid/ready        result_value, result_last, result_empty, capacity_overflow
// csr_chan in   valid/ready (=1)   operation_mode
//
// the beat marked last_of_b starts the job evaluation; each outer element is compared
// against the inner store entry by entry, and the union a pass scans nothing
// (single 32-bit comparator, one read port per set store); intersection takes b as
// outer and scans a, difference takes a as outer and scans b, and the union b pass
// scans a and then the earlier b entries
// req_chan is not ready while a job is evaluated; a stalled rsp_chan holds the sequencer
// synchronous active-high reset clears the counts, flag, mode, sequencer and output valid
module array_set_operation_engine (
   input  logic       clock,
   input  logic       reset,
   aso_req_if.sink    req_chan,
   aso_rsp_if.source  rsp_chan,
   aso_csr_if.sink    csr_chan
);

   localparam int IW = aso_pkg::IDX_W;
   localparam int CW = aso_pkg::CNT_W;
   localparam int DW = aso_pkg::DATA_W;

   // sequencer and counters
   aso_pkg::state_type        state_ff,   state_in;
   aso_pkg::phase_type        phase_ff,   phase_in;
   logic [CW-1:0]             oi_ff,      oi_in;      // outer element index
   logic [CW-1:0]             ii_ff,      ii_in;      // inner scan index
   logic                      inner_b_ff, inner_b_in; // which store is scanned
   logic                      pend_ff,    pend_in;    // read issued last cycle
   logic                      found_ff,   found_in;
   logic [DW-1:0]             cand_ff,    cand_in;    // outer element under test
   logic                      held_v_ff,  held_v_in;  // one-deep hold to know the last
   logic [DW-1:0]             held_ff,    held_in;
   logic [CW-1:0]             count_a_ff, count_a_in;
   logic [CW-1:0]             count_b_ff, count_b_in;
   logic                      ovf_ff,     ovf_in;
   logic [aso_pkg::MODE_W-1:0] mode_ff,   mode_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]             rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff,  rsp_last_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_ovf_ff,   rsp_ovf_in;

   logic          req_fire, rsp_fire, out_free;
   logic          wr_a_en, wr_b_en;
   logic [IW-1:0] a_addr, b_addr;
   logic [DW-1:0] a_rd, b_rd, scan_data;
   logic          outer_b;
   logic [CW-1:0] outer_cnt, inner_lim;
   logic          hit, emit;

   assign req_chan.ready = (state_ff == aso_pkg::ST_LOAD);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid & req_chan.ready;
   assign rsp_fire = rsp_valid_ff & rsp_chan.ready;
   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   // loads go to the store picked by which_set while there is room
   assign wr_a_en = req_fire & (req_chan.which_set == aso_pkg::SEL_A)
                    & (count_a_ff < CW'(aso_pkg::SET_CAPACITY));
   assign wr_b_en = req_fire & (req_chan.which_set == aso_pkg::SEL_B)
                    & (count_b_ff < CW'(aso_pkg::SET_CAPACITY));

   // outer fetch in NEXT, inner reads in SCAN
   assign a_addr = (state_ff == aso_pkg::ST_NEXT) ? oi_ff[IW-1:0] : ii_ff[IW-1:0];
   assign b_addr = (state_ff == aso_pkg::ST_NEXT) ? oi_ff[IW-1:0] : ii_ff[IW-1:0];

   aso_set_store u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (count_a_ff[IW-1:0]),
      .wr_data (req_chan.element_value),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   aso_set_store u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (count_b_ff[IW-1:0]),
      .wr_data (req_chan.element_value),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   assign outer_b   = (phase_ff == aso_pkg::PH_UNION_B) | (phase_ff == aso_pkg::PH_INTER);
   assign outer_cnt = outer_b ? count_b_ff : count_a_ff;
   // union b pass checks only the earlier b entries
   assign inner_lim = inner_b_ff ? ((phase_ff == aso_pkg::PH_UNION_B) ? oi_ff : count_b_ff)
                                 : count_a_ff;
   assign scan_data = inner_b_ff ? b_rd : a_rd;
   // the shared comparator
   assign hit = pend_ff & (scan_data == cand_ff);

   always_comb begin
      case (phase_ff)
         aso_pkg::PH_UNION_A: emit = 1'b1;
         aso_pkg::PH_INTER:   emit = found_ff;
         default:             emit = ~found_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      oi_in        = oi_ff;
      ii_in        = ii_ff;
      inner_b_in   = inner_b_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      cand_in      = cand_ff;
      held_v_in    = held_v_ff;
      held_in      = held_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ovf_in       = ovf_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (csr_chan.valid) begin
         mode_in = csr_chan.operation_mode;
      end

      unique case (state_ff)
         aso_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (wr_a_en) begin
                  count_a_in = count_a_ff + CW'(1);
               end else if (wr_b_en) begin
                  count_b_in = count_b_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_of_b) begin
                  state_in = aso_pkg::ST_START;
               end
            end
         end
         aso_pkg::ST_START: begin
            oi_in    = '0;
            state_in = aso_pkg::ST_NEXT;
            case (mode_ff)
               aso_pkg::MODE_UNION: phase_in = aso_pkg::PH_UNION_A;
               aso_pkg::MODE_INTER: phase_in = aso_pkg::PH_INTER;
               aso_pkg::MODE_DIFF:  phase_in = aso_pkg::PH_DIFF;
               default:             state_in = aso_pkg::ST_FINISH;
            endcase
         end
         aso_pkg::ST_NEXT: begin
            if (oi_ff < outer_cnt) begin
               state_in = aso_pkg::ST_GRAB;
            end else if (phase_ff == aso_pkg::PH_UNION_A) begin
               phase_in = aso_pkg::PH_UNION_B;
               oi_in    = '0;
            end else begin
               state_in = aso_pkg::ST_FINISH;
            end
         end
         aso_pkg::ST_GRAB: begin
            cand_in = outer_b ? b_rd : a_rd;
            if (phase_ff == aso_pkg::PH_UNION_A) begin
               found_in = 1'b0;
               state_in = aso_pkg::ST_DECIDE;
            end else begin
               ii_in      = '0;
               pend_in    = 1'b0;
               inner_b_in = (phase_ff == aso_pkg::PH_DIFF);
               state_in   = aso_pkg::ST_SCAN;
            end
         end
         aso_pkg::ST_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               pend_in  = 1'b0;
               state_in = aso_pkg::ST_DECIDE;
            end else if (ii_ff < inner_lim) begin
               ii_in   = ii_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!inner_b_ff && (phase_ff == aso_pkg::PH_UNION_B)) begin
               // done with a, go on to the earlier b entries
               inner_b_in = 1'b1;
               ii_in      = '0;
               pend_in    = 1'b0;
            end else begin
               found_in = 1'b0;
               pend_in  = 1'b0;
               state_in = aso_pkg::ST_DECIDE;
            end
         end
         aso_pkg::ST_DECIDE: begin
            if (!(emit && held_v_ff && !out_free)) begin
               if (emit) begin
                  if (held_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = held_ff;
                     rsp_last_in  = 1'b0;
                     rsp_empty_in = 1'b0;
                     rsp_ovf_in   = ovf_ff;
                  end
                  held_in   = cand_ff;
                  held_v_in = 1'b1;
               end
               oi_in    = oi_ff + CW'(1);
               state_in = aso_pkg::ST_NEXT;
            end
         end
         aso_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = held_v_ff ? held_ff : '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = ~held_v_ff;
               rsp_ovf_in   = ovf_ff;
               held_v_in    = 1'b0;
               count_a_in   = '0;
               count_b_in   = '0;
               ovf_in       = 1'b0;
               state_in     = aso_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = aso_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aso_pkg::ST_LOAD;
         phase_ff     <= aso_pkg::PH_UNION_A;
         pend_ff      <= 1'b0;
         held_v_ff    <= 1'b0;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ovf_ff       <= 1'b0;
         mode_ff      <= aso_pkg::MODE_UNION;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         held_v_ff    <= held_v_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ovf_ff       <= ovf_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and index registers
   always_ff @(posedge clock) begin
      oi_ff        <= oi_in;
      ii_ff        <= ii_in;
      inner_b_ff   <= inner_b_in;
      found_ff     <= found_in;
      cand_ff      <= cand_in;
      held_ff      <= held_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.result_value      = rsp_value_ff;
   assign rsp_chan.result_last       = rsp_last_ff;
   assign rsp_chan.result_empty      = rsp_empty_ff;
   assign rsp_chan.capacity_overflow = rsp_ovf_ff;

endmodule
